### rtl/tws_pkg.sv
package tws_pkg;

	// Panel size
	localparam int PANEL_COLUMNS = 128;
	localparam int PANEL_ROWS    = 160;

	// Panel controller commands
	localparam logic [7:0] CMD_CASET = 8'h2A;
	localparam logic [7:0] CMD_RASET = 8'h2B;
	localparam logic [7:0] CMD_RAMWR = 8'h2C;

	// Input command codes
	localparam logic CMD_OPEN  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Remaining pixel count
	localparam int              COUNT_W   = 15;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Kind of work the back end carries out
	localparam logic [1:0] KIND_OPEN  = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Byte step within an item's byte sequence
	localparam int          STEP_W         = 4;
	localparam logic [STEP_W-1:0] STEP_PIX_LOW  = 4'd1;
	localparam logic [STEP_W-1:0] STEP_OPEN_END = 4'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [6:0]  col_start;
		logic [6:0]  col_end;
		logic [7:0]  row_start;
		logic [7:0]  row_end;
		logic [15:0] colour;
		logic        done;
	} tws_item_t;

endpackage

### rtl/tws_front.sv
module tws_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [6:0]        col_start,
	input  logic [6:0]        col_end,
	input  logic [7:0]        row_start,
	input  logic [7:0]        row_end,
	input  logic [15:0]       colour,
	input  logic              q_full,
	output logic              q_push,
	output tws_pkg::tws_item_t q_item
);
	import tws_pkg::*;

	logic [COUNT_W-1:0] pixels_left_q;
	logic               accept;
	logic               bad_window;
	logic [7:0]         col_span;
	logic [8:0]         row_span;
	logic [16:0]        product;
	logic [COUNT_W-1:0] count;

	// Take an item whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept;

	// Check the window against its own ends and the panel size
	assign bad_window = (col_start > col_end) || (row_start > row_end) ||
		({2'b00, col_end} >= 9'(PANEL_COLUMNS)) ||
		({1'b0, row_end} >= 9'(PANEL_ROWS));

	// Size the window, both ends inclusive, saturating
	assign col_span = {1'b0, col_end} - {1'b0, col_start} + 8'd1;
	assign row_span = {1'b0, row_end} - {1'b0, row_start} + 9'd1;
	assign product  = {9'd0, col_span} * {8'd0, row_span};
	assign count    = (product > {2'b00, COUNT_MAX}) ? COUNT_MAX : product[COUNT_W-1:0];

	// Classify the item for the back end
	always_comb begin
		q_item.col_start = col_start;
		q_item.col_end   = col_end;
		q_item.row_start = row_start;
		q_item.row_end   = row_end;
		q_item.colour    = colour;
		q_item.done      = (pixels_left_q == COUNT_W'(1));
		if (command == CMD_OPEN) begin
			q_item.kind = bad_window ? KIND_ERROR : KIND_OPEN;
		end else begin
			q_item.kind = (pixels_left_q == '0) ? KIND_ERROR : KIND_PIXEL;
		end
	end

	// Track the pixels left in the open window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_left_q <= '0;
		end else if (accept) begin
			if (command == CMD_OPEN) begin
				pixels_left_q <= bad_window ? '0 : count;
			end else if (pixels_left_q != '0) begin
				pixels_left_q <= pixels_left_q - COUNT_W'(1);
			end
		end
	end

endmodule

### rtl/tws_queue.sv
module tws_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tws_pkg::tws_item_t push_item,
	input  logic               pop,
	output tws_pkg::tws_item_t head_item,
	output logic               full,
	output logic               empty
);
	import tws_pkg::*;

	tws_item_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_item = entries_q[rd_ptr_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

### rtl/tws_back.sv
module tws_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tws_pkg::tws_item_t head_item,
	input  logic               q_empty,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               is_data,
	output logic               last,
	output logic               window_done,
	output logic               error
);
	import tws_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              data_q;
	logic              last_q;
	logic              done_q;
	logic              err_q;
	logic              load;
	logic [7:0]        gen_byte;
	logic              gen_data;
	logic              gen_last;
	logic              gen_done;
	logic              gen_err;

	// Load the output register when it is empty or being drained
	assign load  = !out_valid_q || !out_stall;
	assign q_pop = load && !q_empty && gen_last;

	// Pick the byte for the current step of the head item
	always_comb begin
		gen_byte = 8'h00;
		gen_data = 1'b1;
		gen_last = 1'b0;
		gen_done = 1'b0;
		gen_err  = 1'b0;
		case (head_item.kind)
			KIND_OPEN: begin
				case (step_q)
					4'd0: begin
						gen_byte = CMD_CASET;
						gen_data = 1'b0;
					end
					4'd2: gen_byte = {1'b0, head_item.col_start};
					4'd4: gen_byte = {1'b0, head_item.col_end};
					4'd5: begin
						gen_byte = CMD_RASET;
						gen_data = 1'b0;
					end
					4'd7: gen_byte = head_item.row_start;
					4'd9: gen_byte = head_item.row_end;
					STEP_OPEN_END: begin
						gen_byte = CMD_RAMWR;
						gen_data = 1'b0;
						gen_last = 1'b1;
					end
					default: gen_byte = 8'h00;
				endcase
			end
			KIND_PIXEL: begin
				if (step_q == STEP_PIX_LOW) begin
					gen_byte = head_item.colour[7:0];
					gen_last = 1'b1;
					gen_done = head_item.done;
				end else begin
					gen_byte = head_item.colour[15:8];
				end
			end
			default: begin
				gen_data = 1'b0;
				gen_last = 1'b1;
				gen_err  = 1'b1;
			end
		endcase
	end

	// Advance the step and the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= !q_empty;
			if (!q_empty) begin
				step_q <= gen_last ? '0 : step_q + STEP_W'(1);
			end
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			byte_q <= gen_byte;
			data_q <= gen_data;
			last_q <= gen_last;
			done_q <= gen_done;
			err_q  <= gen_err;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign is_data     = data_q;
	assign last        = last_q;
	assign window_done = done_q;
	assign error       = err_q;

endmodule

### rtl/tft_window_write_sequencer_top.sv
// An item's first result is valid once it has passed through the queue and then the back end's output register.
// The back end sends one result byte per cycle while out_stall is low; an open-window item gives 11 bytes,
// a pixel 2 and an error 1, all through the back end's single output register.
// The front takes one item per cycle until its 4-entry queue is full.
// Reset (arst_n low, asynchronous): queue empty, no result valid, no window open.
module tft_window_write_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [6:0]  col_start,
	input  logic [6:0]  col_end,
	input  logic [7:0]  row_start,
	input  logic [7:0]  row_end,
	input  logic [15:0] colour,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_data,
	output logic        last,
	output logic        window_done,
	output logic        error
);
	import tws_pkg::*;

	tws_item_t push_item;
	tws_item_t head_item;
	logic      q_push;
	logic      q_pop;
	logic      q_full;
	logic      q_empty;

	// Accept and classify items
	tws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.col_start (col_start),
		.col_end   (col_end),
		.row_start (row_start),
		.row_end   (row_end),
		.colour    (colour),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	// Decouple front and back
	tws_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// Emit the byte stream
	tws_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_item   (head_item),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_data     (is_data),
		.last        (last),
		.window_done (window_done),
		.error       (error)
	);

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue pop while empty");

	a_error_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> last && !is_data && !window_done)
		else $error("error result not a lone final result");

	a_done_on_last_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_done |-> is_data && last && !error)
		else $error("window_done off the final pixel byte");

	a_command_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_data && !error |->
			(out_byte == CMD_CASET) || (out_byte == CMD_RASET) || (out_byte == CMD_RAMWR))
		else $error("unknown command byte");
`endif

endmodule

### dv/tb_tft_window_write_sequencer_top.sv
`timescale 1ns / 100ps

import tws_pkg::*;

typedef struct {
	logic [7:0] value;
	logic       dc;
	logic       last;
	logic       done;
	logic       err;
} panel_byte_t;

// Predict the panel byte stream and check what the block sends
class window_byte_scoreboard;
	panel_byte_t        expected_q[$];
	logic [COUNT_W-1:0] pixels_left;
	int                 mismatches;
	int                 bytes_checked;
	int                 windows_opened;
	int                 pixels_written;
	int                 rejects;

	function new();
		pixels_left    = '0;
		mismatches     = 0;
		bytes_checked  = 0;
		windows_opened = 0;
		pixels_written = 0;
		rejects        = 0;
	endfunction

	function void push_byte(logic [7:0] value, logic dc, logic lst, logic done, logic err);
		panel_byte_t b;
		b.value = value;
		b.dc    = dc;
		b.last  = lst;
		b.done  = done;
		b.err   = err;
		expected_q.push_back(b);
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	// Work out the bytes one accepted transfer causes
	function void note_item(logic cmd, logic [6:0] cs, logic [6:0] ce, logic [7:0] rs,
			logic [7:0] re, logic [15:0] colour);
		int unsigned count;
		if (cmd == CMD_OPEN) begin
			if (cs > ce || rs > re || ce >= PANEL_COLUMNS || re >= PANEL_ROWS) begin
				// bad window closes whatever was open
				pixels_left = '0;
				rejects++;
				push_byte(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
			end else begin
				count = (int'(ce) - int'(cs) + 1) * (int'(re) - int'(rs) + 1);
				if (count > COUNT_MAX)
					count = COUNT_MAX;
				pixels_left = count[COUNT_W-1:0];
				windows_opened++;
				push_byte(CMD_CASET, 1'b0, 1'b0, 1'b0, 1'b0);
				push_byte(8'h00,     1'b1, 1'b0, 1'b0, 1'b0);
				push_byte({1'b0, cs}, 1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(8'h00,     1'b1, 1'b0, 1'b0, 1'b0);
				push_byte({1'b0, ce}, 1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(CMD_RASET, 1'b0, 1'b0, 1'b0, 1'b0);
				push_byte(8'h00,     1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(rs,        1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(8'h00,     1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(re,        1'b1, 1'b0, 1'b0, 1'b0);
				push_byte(CMD_RAMWR, 1'b0, 1'b1, 1'b0, 1'b0);
			end
		end else if (pixels_left == '0) begin
			// pixel with nothing left to fill
			rejects++;
			push_byte(8'h00, 1'b0, 1'b1, 1'b0, 1'b1);
		end else begin
			pixels_left = pixels_left - 1'b1;
			pixels_written++;
			push_byte(colour[15:8], 1'b1, 1'b0, 1'b0, 1'b0);
			push_byte(colour[7:0],  1'b1, 1'b1, pixels_left == '0, 1'b0);
		end
	endfunction

	// Compare one output transfer with the oldest prediction
	function void check_byte(logic [7:0] value, logic dc, logic lst, logic done, logic err);
		panel_byte_t e;
		bytes_checked++;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR %0t: unexpected byte %h dc=%b last=%b done=%b err=%b",
					$time, value, dc, lst, done, err);
			return;
		end
		e = expected_q.pop_front();
		if (value !== e.value || dc !== e.dc || lst !== e.last || done !== e.done ||
				err !== e.err) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR %0t: exp byte %h dc=%b last=%b done=%b err=%b, got byte %h dc=%b last=%b done=%b err=%b",
					$time, e.value, e.dc, e.last, e.done, e.err,
					value, dc, lst, done, err);
		end
	endfunction
endclass

module tb_tft_window_write_sequencer_top;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 100;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [6:0]  col_start;
	logic [6:0]  col_end;
	logic [7:0]  row_start;
	logic [7:0]  row_end;
	logic [15:0] colour;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        is_data;
	logic        last;
	logic        window_done;
	logic        error;

	window_byte_scoreboard sb = new();

	int items_sent;
	int hold_cycles;
	int cycles;
	bit no_gaps;

	tft_window_write_sequencer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.col_start   (col_start),
		.col_end     (col_end),
		.row_start   (row_start),
		.row_end     (row_end),
		.colour      (colour),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.is_data     (is_data),
		.last        (last),
		.window_done (window_done),
		.error       (error)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Give up at the cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycles, sb.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Drive the output stall: a forced hold-off, random gaps otherwise
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (!no_gaps && $urandom_range(0, 99) < 11)
				out_stall <= 1'b1;
			else
				out_stall <= 1'b0;
		end
	end

	// Check each output transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_byte(out_byte, is_data, last, window_done, error);
	end

	// Offer one item and hold it until the block takes it
	task automatic send_item(logic cmd, logic [6:0] cs, logic [6:0] ce, logic [7:0] rs,
			logic [7:0] re, logic [15:0] pix);
		@(negedge clk);
		while (!no_gaps && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		col_start <= cs;
		col_end   <= ce;
		row_start <= rs;
		row_end   <= re;
		colour    <= pix;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_item(cmd, cs, ce, rs, re, pix);
		items_sent++;
	endtask

	task automatic send_random_pixel();
		send_item(CMD_PIXEL, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			16'($urandom_range(0, 65535)));
	endtask

	// Open a small legal window and fill it, sometimes short or over by one
	task automatic send_window_burst();
		int w;
		int h;
		int cs;
		int rs;
		int npix;
		w    = $urandom_range(1, 3);
		h    = $urandom_range(1, 3);
		cs   = $urandom_range(0, PANEL_COLUMNS - w);
		rs   = $urandom_range(0, PANEL_ROWS - h);
		npix = w * h;
		if ($urandom_range(0, 5) == 0)
			npix = $urandom_range(0, npix);
		else if ($urandom_range(0, 5) == 0)
			npix++;
		send_item(CMD_OPEN, 7'(cs), 7'(cs + w - 1), 8'(rs), 8'(rs + h - 1),
			16'($urandom_range(0, 65535)));
		repeat (npix)
			send_random_pixel();
	endtask

	// Reversed window, or any field pattern at all
	task automatic send_noise();
		int cs;
		int rs;
		if ($urandom_range(0, 1) == 0) begin
			cs = $urandom_range(1, 127);
			rs = $urandom_range(1, 255);
			if ($urandom_range(0, 1) == 0)
				send_item(CMD_OPEN, 7'(cs), 7'($urandom_range(0, cs - 1)),
					8'($urandom_range(0, 159)), 8'($urandom_range(0, 255)), 16'($urandom));
			else
				send_item(CMD_OPEN, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
					8'(rs), 8'($urandom_range(0, rs - 1)), 16'($urandom));
		end else begin
			send_item(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
				7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		int directed_items;
		int r;

		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = CMD_OPEN;
		col_start   = '0;
		col_end     = '0;
		row_start   = '0;
		row_end     = '0;
		colour      = '0;
		items_sent  = 0;
		hold_cycles = 0;
		cycles      = 0;
		no_gaps     = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: pixel before any window
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h1234);
		// one-pixel window, fill it, then one too many
		send_item(CMD_OPEN, 7'd0, 7'd0, 8'd0, 8'd0, 16'h0000);
		send_item(CMD_PIXEL, 7'd127, 7'd127, 8'd255, 8'd255, 16'hFFFF);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h0000);
		// whole panel, one pixel, then closed by a reversed column range
		send_item(CMD_OPEN, 7'd0, 7'd127, 8'd0, 8'd159, 16'hFFFF);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h8001);
		send_item(CMD_OPEN, 7'd5, 7'd4, 8'd0, 8'd0, 16'h0000);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h7FFE);
		// reversed rows, rows past the panel edge
		send_item(CMD_OPEN, 7'd0, 7'd0, 8'd9, 8'd8, 16'h0000);
		send_item(CMD_OPEN, 7'd0, 7'd3, 8'd0, 8'd160, 16'h0000);
		send_item(CMD_OPEN, 7'd0, 7'd0, 8'd255, 8'd255, 16'h0000);
		// corner window, partly filled, then replaced by a new one
		send_item(CMD_OPEN, 7'd126, 7'd127, 8'd158, 8'd159, 16'h0000);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'hA55A);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h0F0F);
		send_item(CMD_OPEN, 7'd127, 7'd127, 8'd159, 8'd159, 16'h0000);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h00FF);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'hFF00);
		// two-pixel window filled exactly
		send_item(CMD_OPEN, 7'd10, 7'd11, 8'd20, 8'd20, 16'h0000);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'hFF00);
		send_item(CMD_PIXEL, 7'd0, 7'd0, 8'd0, 8'd0, 16'h5AA5);
		directed_items = items_sent;

		// Pause the sender until the block has drained
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);

		// Random: mostly legal windows with their pixels, some noise
		while (items_sent < directed_items + RANDOM_ITEMS) begin
			if (hold_cycles == 0 && items_sent >= directed_items + 15 &&
					items_sent < directed_items + 20)
				hold_cycles = 80;
			no_gaps = (items_sent >= directed_items + 50 && items_sent < directed_items + 85);
			r = $urandom_range(0, 99);
			if (r < 70)
				send_window_burst();
			else
				send_noise();
		end
		no_gaps = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then let any stray bytes show up
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("covered %0d items: %0d windows opened, %0d pixels written, %0d rejected",
			items_sent, sb.windows_opened, sb.pixels_written, sb.rejects);
		$display("%0d bytes checked, %0d mismatches", sb.bytes_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
